// File: hdl/aesecb_pkg.sv
// Shared types, constants and byte-level functions of the AES ECB cipher block.
`default_nettype none
package aesecb_pkg;

    typedef logic [7:0]   t_byte;
    typedef logic [31:0]  t_word;
    typedef logic [127:0] t_block;
    typedef logic [255:0][7:0] t_sbox_tbl;

    localparam logic [8:0] GF_POLY      = 9'h11B;
    localparam logic [7:0] GF_HIGH_BIT  = 8'h80;
    localparam logic [7:0] BYTE_MASK    = 8'hFF;
    localparam logic [7:0] AFFINE_FWD   = 8'h63;
    localparam logic [7:0] AFFINE_INV   = 8'h05;
    localparam logic [7:0] RCON_FIRST   = 8'h01;

    typedef enum logic [2:0] {
        CFG_DIRECTION = 3'd0,
        CFG_KEY_SIZE  = 3'd1,
        CFG_KEY_0     = 3'd2,
        CFG_KEY_1     = 3'd3,
        CFG_KEY_2     = 3'd4,
        CFG_KEY_3     = 3'd5
    } t_cfg_idx;

    localparam logic [1:0] KS_AES128 = 2'd0;
    localparam logic [1:0] KS_AES192 = 2'd1;

    localparam logic DIR_ENCRYPT = 1'b0;

    typedef struct packed {
        logic busy;   // item in flight
        logic done;   // result waits for the output register
    } t_core_status;

    function automatic t_byte f_xtime(input t_byte a);
        return {a[6:0], 1'b0} ^ (((a & GF_HIGH_BIT) != 8'h00) ? GF_POLY[7:0] : 8'h00);
    endfunction

    function automatic t_byte f_gf_mul(input t_byte a, input t_byte b);
        t_byte acc;
        t_byte x;
        acc = 8'h00;
        x   = a;
        for (int i = 0; i < 8; i++) begin
            if (b[i]) acc = acc ^ x;
            x = f_xtime(x);
        end
        return acc;
    endfunction

    function automatic t_byte f_gf_inv(input t_byte a);
        t_byte r;
        t_byte p;
        logic [7:0] e;
        r = 8'h01;
        p = a;
        e = 8'd254;
        for (int i = 0; i < 8; i++) begin
            if (e[i]) r = f_gf_mul(r, p);
            p = f_gf_mul(p, p);
        end
        return r;
    endfunction

    function automatic t_byte f_rotl8(input t_byte x, input int n);
        return t_byte'((x << n) | (x >> (8 - n)));
    endfunction

    function automatic t_sbox_tbl f_gen_sbox();
        t_sbox_tbl tbl;
        t_byte b;
        for (int x = 0; x < 256; x++) begin
            b = f_gf_inv(t_byte'(x));
            tbl[x] = (b ^ f_rotl8(b, 1) ^ f_rotl8(b, 2) ^ f_rotl8(b, 3) ^ f_rotl8(b, 4)
                      ^ AFFINE_FWD) & BYTE_MASK;
        end
        return tbl;
    endfunction

    function automatic t_sbox_tbl f_gen_inv_sbox();
        t_sbox_tbl tbl;
        t_byte b;
        for (int x = 0; x < 256; x++) begin
            b = f_rotl8(t_byte'(x), 1) ^ f_rotl8(t_byte'(x), 3) ^ f_rotl8(t_byte'(x), 6)
                ^ AFFINE_INV;
            tbl[x] = f_gf_inv(b);
        end
        return tbl;
    endfunction

    localparam t_sbox_tbl SBOX_TBL     = f_gen_sbox();
    localparam t_sbox_tbl INV_SBOX_TBL = f_gen_inv_sbox();

    function automatic t_word f_sub_word(input t_word w);
        return {SBOX_TBL[w[31:24]], SBOX_TBL[w[23:16]], SBOX_TBL[w[15:8]], SBOX_TBL[w[7:0]]};
    endfunction

    function automatic t_word f_mix_col(input t_word c);
        t_byte a0, a1, a2, a3;
        a0 = c[31:24]; a1 = c[23:16]; a2 = c[15:8]; a3 = c[7:0];
        return {f_xtime(a0) ^ f_xtime(a1) ^ a1 ^ a2 ^ a3,
                a0 ^ f_xtime(a1) ^ f_xtime(a2) ^ a2 ^ a3,
                a0 ^ a1 ^ f_xtime(a2) ^ f_xtime(a3) ^ a3,
                f_xtime(a0) ^ a0 ^ a1 ^ a2 ^ f_xtime(a3)};
    endfunction

    function automatic t_word f_inv_mix_col(input t_word c);
        t_byte a  [4];
        t_byte m9 [4];
        t_byte m11[4];
        t_byte m13[4];
        t_byte m14[4];
        t_byte x2, x4, x8;
        for (int k = 0; k < 4; k++) begin
            a[k]   = c[31 - 8*k -: 8];
            x2     = f_xtime(a[k]);
            x4     = f_xtime(x2);
            x8     = f_xtime(x4);
            m9[k]  = x8 ^ a[k];
            m11[k] = x8 ^ x2 ^ a[k];
            m13[k] = x8 ^ x4 ^ a[k];
            m14[k] = x8 ^ x4 ^ x2;
        end
        return {m14[0] ^ m11[1] ^ m13[2] ^ m9[3],
                m9[0]  ^ m14[1] ^ m11[2] ^ m13[3],
                m13[0] ^ m9[1]  ^ m14[2] ^ m11[3],
                m11[0] ^ m13[1] ^ m9[2]  ^ m14[3]};
    endfunction

    function automatic t_block f_shift_rows(input t_block s, input logic inv);
        t_block t;
        int src;
        for (int c = 0; c < 4; c++) begin
            for (int r = 0; r < 4; r++) begin
                src = inv ? ((c + 4 - r) % 4) : ((c + r) % 4);
                t[127 - 8*(4*c + r) -: 8] = s[127 - 8*(4*src + r) -: 8];
            end
        end
        return t;
    endfunction

endpackage
`default_nettype wire

// File: hdl/aesecb_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module aesecb_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 60
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) r_mem[i_waddr] <= i_wdata;
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

// File: hdl/aesecb_keyexp.sv
// Key expansion sequencer: one schedule word per cycle into the round key RAM.
`default_nettype none
module aesecb_keyexp #(
    parameter int SCHEDULE_WORDS = 60
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_start,
    input  wire logic [1:0]                        i_key_size,
    input  wire logic [3:0][63:0]                  i_key,
    output logic                                   o_busy,
    output logic [3:0]                             o_nr,
    output logic                                   o_we,
    output logic [$clog2(SCHEDULE_WORDS)-1:0]      o_waddr,
    output aesecb_pkg::t_word                      o_wdata
);
    import aesecb_pkg::*;

    localparam int AW     = $clog2(SCHEDULE_WORDS);
    localparam int CW     = $clog2(SCHEDULE_WORDS + 1);
    localparam int MAX_NR = SCHEDULE_WORDS / 4 - 1;

    logic            r_busy;
    logic [CW-1:0]   r_idx;
    logic [2:0]      r_j;
    t_byte           r_rcon;
    logic [7:0][31:0] r_win;

    logic [3:0]  nk;
    logic [3:0]  nr_full;
    logic [CW-1:0] total;
    t_word       key_word;
    t_word       t_prev;
    t_word       w_old;
    t_word       n_word;
    logic        last_j;

    always_comb begin
        case (i_key_size)
            KS_AES128: nk = 4'd4;
            KS_AES192: nk = 4'd6;
            default:   nk = 4'd8;
        endcase
        nr_full = nk + 4'd6;
        o_nr    = (nr_full > 4'(MAX_NR)) ? 4'(MAX_NR) : nr_full;
        total   = CW'({o_nr, 2'b00}) + CW'(4);
        last_j  = ({1'b0, r_j} == nk - 4'd1);

        key_word = r_idx[0] ? i_key[r_idx[2:1]][31:0] : i_key[r_idx[2:1]][63:32];

        case (nk)
            4'd4:    w_old = r_win[3];
            4'd6:    w_old = r_win[5];
            default: w_old = r_win[7];
        endcase

        t_prev = r_win[0];
        if (r_j == 3'd0) begin
            t_prev = f_sub_word({t_prev[23:0], t_prev[31:24]}) ^ {r_rcon, 24'h0};
        end else if (nk == 4'd8 && r_j == 3'd4) begin
            t_prev = f_sub_word(t_prev);
        end

        n_word = (r_idx < CW'(nk)) ? key_word : (w_old ^ t_prev);
    end

    assign o_busy  = r_busy;
    assign o_we    = r_busy;
    assign o_waddr = AW'(r_idx);
    assign o_wdata = n_word;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_idx  <= '0;
            r_j    <= '0;
            r_rcon <= RCON_FIRST;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_idx  <= '0;
            r_j    <= '0;
            r_rcon <= RCON_FIRST;
        end else if (r_busy) begin
            r_win <= {r_win[6:0], n_word};
            r_idx <= r_idx + CW'(1);
            r_j   <= last_j ? 3'd0 : r_j + 3'd1;
            if (r_j == 3'd0 && r_idx >= CW'(nk)) r_rcon <= f_xtime(r_rcon);
            if (r_idx == total - CW'(1)) r_busy <= 1'b0;
        end
    end
endmodule
`default_nettype wire

// File: hdl/aesecb_core.sv
// Round sequencer: byte-serial S-box pass and column-serial mix and key add.
`default_nettype none
module aesecb_core #(
    parameter int AW = 6
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_start,
    input  wire aesecb_pkg::t_block        i_block,
    input  wire logic                      i_dir,
    input  wire logic [3:0]                i_nr,
    input  wire aesecb_pkg::t_word         i_rk,
    input  wire logic                      i_take,
    output logic [AW-1:0]                  o_raddr,
    output aesecb_pkg::t_block             o_block,
    output aesecb_pkg::t_core_status       o_status
);
    import aesecb_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_COL,
        ST_SHIFT,
        ST_SUB,
        ST_DONE
    } t_state;

    t_state     r_state;
    t_block     r_st;
    logic [3:0] r_rd;
    logic [3:0] r_cnt;
    logic       r_dir;
    logic [3:0] r_nr;

    logic [3:0] key_round;
    logic       mix_en;
    t_word      col_in;
    t_word      col_x;
    t_word      col_out;
    t_byte      sub_out;

    always_comb begin
        key_round = (r_dir == DIR_ENCRYPT) ? r_rd : (r_nr - r_rd);
        o_raddr   = AW'({key_round, r_cnt[1:0]});
        mix_en    = (r_rd != 4'd0) && (r_rd != r_nr);
        col_in    = r_st[127:96];
        if (r_dir == DIR_ENCRYPT) begin
            col_x   = mix_en ? f_mix_col(col_in) : col_in;
            col_out = col_x ^ i_rk;
        end else begin
            col_x   = col_in ^ i_rk;
            col_out = mix_en ? f_inv_mix_col(col_x) : col_x;
        end
        sub_out = (r_dir == DIR_ENCRYPT) ? SBOX_TBL[r_st[127:120]]
                                          : INV_SBOX_TBL[r_st[127:120]];
    end

    assign o_block       = r_st;
    assign o_status.busy = (r_state != ST_IDLE);
    assign o_status.done = (r_state == ST_DONE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_rd    <= '0;
            r_cnt   <= '0;
        end else begin
            case (r_state)
                ST_IDLE: begin
                    if (i_start) begin
                        r_st    <= i_block;
                        r_dir   <= i_dir;
                        r_nr    <= i_nr;
                        r_rd    <= '0;
                        r_cnt   <= '0;
                        r_state <= ST_COL;
                    end
                end
                ST_COL: begin
                    // first cycle only fetches column 0's key word
                    if (r_cnt != 4'd0) r_st <= {r_st[95:0], col_out};
                    if (r_cnt == 4'd4) begin
                        r_cnt <= '0;
                        if (r_rd == r_nr) begin
                            r_state <= ST_DONE;
                        end else begin
                            r_rd    <= r_rd + 4'd1;
                            r_state <= ST_SHIFT;
                        end
                    end else begin
                        r_cnt <= r_cnt + 4'd1;
                    end
                end
                ST_SHIFT: begin
                    r_st    <= f_shift_rows(r_st, r_dir);
                    r_state <= ST_SUB;
                end
                ST_SUB: begin
                    r_st <= {r_st[119:0], sub_out};
                    if (r_cnt == 4'd15) begin
                        r_cnt   <= '0;
                        r_state <= ST_COL;
                    end else begin
                        r_cnt <= r_cnt + 4'd1;
                    end
                end
                ST_DONE: begin
                    if (i_take) r_state <= ST_IDLE;
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

// File: hdl/aes_block_cipher_ecb_top.sv
// AES-128/192/256 ECB block cipher, byte-serial rounds, top level.
// An accepted block gets the first key add, then Nr rounds (Nr = 10, 12, 14) of
// ShiftRows, the single S-box byte lane and the column-serial mix/key-add unit;
// one item in flight: no new item is accepted until the core hands its result on.
// A key or key_size write rebuilds the schedule, one word per cycle (44..60 words).
// Reset (synchronous, active low) clears the control and config registers and
// starts an all-zero AES-128 key expansion; input stalls until it finishes.
`default_nettype none
module aes_block_cipher_ecb_top #(
    parameter int SCHEDULE_WORDS = 60
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // configuration write port
    input  wire logic        i_cfg_we,
    input  wire logic [2:0]  i_cfg_index,
    input  wire logic [63:0] i_cfg_data,
    // input item channel
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire logic [63:0] i_block_high,
    input  wire logic [63:0] i_block_low,
    // result item channel
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output logic [63:0]      o_result_high,
    output logic [63:0]      o_result_low
);
    import aesecb_pkg::*;

    localparam int AW = $clog2(SCHEDULE_WORDS);

    // configuration registers
    logic             r_dir;
    logic [1:0]       r_key_size;
    logic [3:0][63:0] r_key;
    logic             r_kx_start;   // schedule rebuild pending
    logic             n_kx_start;

    // result register
    logic             r_out_valid;
    logic [63:0]      r_res_hi;
    logic [63:0]      r_res_lo;

    logic             kx_busy;
    logic [3:0]       kx_nr;
    logic             kx_we;
    logic [AW-1:0]    kx_waddr;
    t_word            kx_wdata;

    logic [AW-1:0]    core_raddr;
    t_word            rk_data;
    t_block           core_block;
    t_core_status     core_status;

    logic             in_accept;
    logic             take;

    // any write to key size or key bits forces a rebuild of the schedule
    always_comb begin
        n_kx_start = 1'b0;
        if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_KEY_SIZE, CFG_KEY_0, CFG_KEY_1, CFG_KEY_2, CFG_KEY_3: n_kx_start = 1'b1;
                default: n_kx_start = 1'b0;
            endcase
        end
    end

    // hold off new items while the schedule is stale or a block is in the rounds
    assign o_in_stall = core_status.busy | kx_busy | r_kx_start;
    assign in_accept  = i_in_valid & ~o_in_stall;

    // move a finished block out when the result register is free or draining
    assign take = core_status.done & (~r_out_valid | ~i_out_stall);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dir       <= 1'b0;
            r_key_size  <= '0;
            r_key       <= '0;
            r_kx_start  <= 1'b1;
            r_out_valid <= 1'b0;
        end else begin
            r_kx_start <= n_kx_start;
            if (i_cfg_we) begin
                case (t_cfg_idx'(i_cfg_index))
                    CFG_DIRECTION: r_dir      <= i_cfg_data[0];
                    CFG_KEY_SIZE:  r_key_size <= i_cfg_data[1:0];
                    CFG_KEY_0:     r_key[0]   <= i_cfg_data;
                    CFG_KEY_1:     r_key[1]   <= i_cfg_data;
                    CFG_KEY_2:     r_key[2]   <= i_cfg_data;
                    CFG_KEY_3:     r_key[3]   <= i_cfg_data;
                    default: ;    // drop writes beyond the register list
                endcase
            end
            if (take)                   r_out_valid <= 1'b1;
            else if (~i_out_stall)      r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_res_hi <= core_block[127:64];
            r_res_lo <= core_block[63:0];
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_result_high = r_res_hi;
    assign o_result_low  = r_res_lo;

    aesecb_keyexp #(
        .SCHEDULE_WORDS (SCHEDULE_WORDS)
    ) u_keyexp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (r_kx_start),
        .i_key_size (r_key_size),
        .i_key      (r_key),
        .o_busy     (kx_busy),
        .o_nr       (kx_nr),
        .o_we       (kx_we),
        .o_waddr    (kx_waddr),
        .o_wdata    (kx_wdata)
    );

    aesecb_ram #(
        .WIDTH (32),
        .DEPTH (SCHEDULE_WORDS)
    ) u_rk_ram (
        .i_clk   (i_clk),
        .i_we    (kx_we),
        .i_waddr (kx_waddr),
        .i_wdata (kx_wdata),
        .i_raddr (core_raddr),
        .o_rdata (rk_data)
    );

    aesecb_core #(
        .AW (AW)
    ) u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (in_accept),
        .i_block  ({i_block_high, i_block_low}),
        .i_dir    (r_dir),
        .i_nr     (kx_nr),
        .i_rk     (rk_data),
        .i_take   (take),
        .o_raddr  (core_raddr),
        .o_block  (core_block),
        .o_status (core_status)
    );
endmodule
`default_nettype wire

// File: hdl/aesecb_checker.sv
// Port-level checker for the AES ECB cipher top level, with its bind.
`default_nettype none
module aesecb_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_cfg_we,
    input wire logic [2:0]  i_cfg_index,
    input wire logic [63:0] i_cfg_data,
    input wire logic        i_in_valid,
    input wire logic        o_in_stall,
    input wire logic [63:0] i_block_high,
    input wire logic [63:0] i_block_low,
    input wire logic        o_out_valid,
    input wire logic        i_out_stall,
    input wire logic [63:0] o_result_high,
    input wire logic [63:0] o_result_low
);
    import aesecb_pkg::*;

    // a stalled result item holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_result_high)
                                       && $stable(o_result_low))
        else $error("stalled result item changed");

    // reset always leads into a schedule build, so input stalls
    a_rst_stall: assert property (@(posedge i_clk)
        !i_rst_n |=> o_in_stall)
        else $error("input not stalled after reset");

    // one item in flight: accepting an item closes the input
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("second item could enter while one is in the rounds");

    // a key write blocks items until the schedule is rebuilt
    a_key_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_we && (i_cfg_index == CFG_KEY_SIZE || i_cfg_index == CFG_KEY_0 ||
                     i_cfg_index == CFG_KEY_1 || i_cfg_index == CFG_KEY_2 ||
                     i_cfg_index == CFG_KEY_3) |=> o_in_stall)
        else $error("input open while schedule is stale");

    // no result can appear the cycle after an item enters
    a_no_instant: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> !$rose(o_out_valid))
        else $error("result appeared right after accept");
endmodule

bind aes_block_cipher_ecb_top aesecb_checker u_checker (.*);
`default_nettype wire
